// ===== rtl/core/ddwrl_pkg.sv =====
// Shared types and constants for the differential-drive wheel rpm limiter.
package ddwrl_pkg;

  localparam int MAG_W  = 32;  // magnitude of linear / tangential term, um/min
  localparam int SCL_W  = 17;  // Q1.16 scale factor, up to 1.0
  localparam int PROD_W = MAG_W + SCL_W;
  localparam int SUM_W  = 35;  // signed L +/- T
  localparam int DVD_W  = 38;  // |L +/- T| * 16
  localparam int DVS_W  = 21;  // circumference
  localparam int CFG_W  = 21;
  localparam int RPM_W  = 17;

  localparam int MUL_STEPS = SCL_W;
  localparam int DIV_STEPS = DVD_W;

  localparam logic [SCL_W-1:0] SCALE_ONE  = 17'd65536;
  localparam logic [SCL_W-1:0] SCALE_STEP = 17'd2185;
  localparam logic [SCL_W-1:0] LIN_GAIN   = 17'd60000;

  localparam logic [1:0] CFG_CIRC   = 2'd0;
  localparam logic [1:0] CFG_TRACK  = 2'd1;
  localparam logic [1:0] CFG_MAXRPM = 2'd2;

  localparam logic [DVS_W-1:0] CIRC_RST   = 21'd213628;
  localparam logic [11:0]      TRACK_RST  = 12'd200;
  localparam logic [11:0]      MAXRPM_RST = 12'd900;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_GO,
    ST_MUL_WAIT,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_CHECK,
    ST_OUT
  } state_t;

endpackage

// ===== rtl/core/ddwrl_smul.sv =====
// Bit-serial unsigned multiplier, one multiplier bit per cycle.
module ddwrl_smul (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [ddwrl_pkg::MAG_W-1:0]   mcand,
  input  logic [ddwrl_pkg::SCL_W-1:0]   mplier,
  output logic [ddwrl_pkg::PROD_W-1:0]  prod,
  output logic                          done
);
  import ddwrl_pkg::*;

  localparam int CNT_W = $clog2(MUL_STEPS);

  logic [MAG_W-1:0] a;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [MAG_W:0]   sum;

  // upper half accumulates, lower half shifts the multiplier out
  assign sum = {1'b0, prod[PROD_W-1:SCL_W]} + (prod[0] ? {1'b0, a} : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(MUL_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a    <= mcand;
      prod <= {{MAG_W{1'b0}}, mplier};
    end else if (busy) begin
      prod <= {sum, prod[SCL_W-1:1]};
    end
  end

endmodule

// ===== rtl/core/ddwrl_sdiv.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
module ddwrl_sdiv (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [ddwrl_pkg::DVD_W-1:0]  dividend,
  input  logic [ddwrl_pkg::DVS_W-1:0]  divisor,
  output logic [ddwrl_pkg::DVD_W-1:0]  quot,
  output logic                         done
);
  import ddwrl_pkg::*;

  localparam int CNT_W = $clog2(DIV_STEPS);

  logic [DVS_W-1:0] dvs;
  logic [DVS_W:0]   rem;
  logic [DVS_W:0]   rsh;
  logic             ge;
  logic [CNT_W-1:0] cnt;
  logic             busy;

  assign rsh = {rem[DVS_W-1:0], quot[DVD_W-1]};
  assign ge  = rsh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // quot holds the dividend and fills with quotient bits from the bottom
  always_ff @(posedge clk) begin
    if (start) begin
      quot <= dividend;
      rem  <= '0;
      dvs  <= (divisor == '0) ? DVS_W'(1) : divisor;
    end else if (busy) begin
      rem  <= ge ? (rsh - {1'b0, dvs}) : rsh;
      quot <= {quot[DVD_W-2:0], ge};
    end
  end

endmodule

// ===== rtl/core/diff_drive_wheel_rpm_limiter_core.sv =====
// Differential-drive wheel rpm limiter: top level, control and datapath registers.
// Turns (linear_vel mm/s, angular_vel mrad/s) into left/right wheel speeds in 1/16 rpm,
// shrinking both terms by compounding factors 1 - k*2185/65536 until both wheels are
// within 16*max_rpm; after MAX_ROUNDS failed rounds both outputs are zero. One command
// at a time. Each pass (the first, then one per shrink round) runs the bit-serial multipliers
// (17 steps), then the bit-serial dividers (38 steps), then the limit check; the first pass
// multiplies by the gains, later ones by the shrink factor. A finished result waits in the
// output register while the next command is taken; the input opens in the cycle after the
// result is loaded. cfg_ready is always high; write registers only while idle.
module diff_drive_wheel_rpm_limiter_core #(
  parameter int MAX_ROUNDS = 30
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [15:0]            linear_vel,
  input  logic signed [15:0]            angular_vel,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [ddwrl_pkg::RPM_W-1:0] left_rpm,
  output logic signed [ddwrl_pkg::RPM_W-1:0] right_rpm,
  output logic                          was_scaled,
  output logic [4:0]                    scale_rounds,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [1:0]                    cfg_index,
  input  logic [ddwrl_pkg::CFG_W-1:0]   cfg_data
);
  import ddwrl_pkg::*;

  localparam int RW = $clog2(MAX_ROUNDS + 1);

  state_t state, state_next;

  logic [DVS_W-1:0] circ;
  logic [11:0]      track;
  logic [11:0]      max_rpm;

  logic             lin_neg, tan_neg;
  logic [MAG_W-1:0] lin_mag, tan_mag;
  logic [SCL_W-1:0] scale;
  logic [RW-1:0]    rounds;
  logic             first;
  logic             left_neg, right_neg;
  logic             ok_r;

  logic             mul_start, div_start, load_out, accept;
  logic [SCL_W-1:0] track30;
  logic [PROD_W-1:0] prod_l, prod_t;
  logic             done_ml, done_mt, mul_done;
  logic [DVD_W-1:0] quot_l, quot_r;
  logic             done_dl, done_dr, div_done;
  logic signed [SUM_W-1:0] lin_s, tan_s, dl, dr;
  logic [SUM_W-1:0] dl_mag, dr_mag;
  logic [DVD_W-1:0] lim;
  logic             ok_now, rounds_max;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !in_stall;
  assign track30   = {track, 5'b0} - {4'b0, track, 1'b0};
  assign mul_done  = done_ml && done_mt;
  assign div_done  = done_dl && done_dr;

  assign lin_s  = lin_neg ? -SUM_W'(lin_mag) : SUM_W'(lin_mag);
  assign tan_s  = tan_neg ? -SUM_W'(tan_mag) : SUM_W'(tan_mag);
  assign dl     = lin_s - tan_s;
  assign dr     = lin_s + tan_s;
  assign dl_mag = dl[SUM_W-1] ? -dl : dl;
  assign dr_mag = dr[SUM_W-1] ? -dr : dr;

  assign lim        = {{(DVD_W-16){1'b0}}, max_rpm, 4'b0};
  assign ok_now     = (quot_l <= lim) && (quot_r <= lim);
  assign rounds_max = int'(rounds) >= MAX_ROUNDS;

  ddwrl_smul u_mul_lin (
    .clk, .rst, .start(mul_start), .mcand(lin_mag),
    .mplier(first ? LIN_GAIN : scale), .prod(prod_l), .done(done_ml)
  );

  ddwrl_smul u_mul_tan (
    .clk, .rst, .start(mul_start), .mcand(tan_mag),
    .mplier(first ? track30 : scale), .prod(prod_t), .done(done_mt)
  );

  ddwrl_sdiv u_div_left (
    .clk, .rst, .start(div_start), .dividend({dl_mag[SUM_W-2:0], 4'b0}),
    .divisor(circ), .quot(quot_l), .done(done_dl)
  );

  ddwrl_sdiv u_div_right (
    .clk, .rst, .start(div_start), .dividend({dr_mag[SUM_W-2:0], 4'b0}),
    .divisor(circ), .quot(quot_r), .done(done_dr)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      circ    <= CIRC_RST;
      track   <= TRACK_RST;
      max_rpm <= MAXRPM_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_CIRC:   circ    <= cfg_data;
        CFG_TRACK:  track   <= cfg_data[11:0];
        CFG_MAXRPM: max_rpm <= cfg_data[11:0];
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:     if (accept) state_next = ST_MUL_GO;
      ST_MUL_GO:   state_next = ST_MUL_WAIT;
      ST_MUL_WAIT: if (mul_done) state_next = ST_DIV_GO;
      ST_DIV_GO:   state_next = ST_DIV_WAIT;
      ST_DIV_WAIT: if (div_done) state_next = ST_CHECK;
      ST_CHECK:    state_next = (ok_now || rounds_max) ? ST_OUT : ST_MUL_GO;
      ST_OUT:      if (load_out) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = 1'b1;
    mul_start = 1'b0;
    div_start = 1'b0;
    load_out  = 1'b0;
    case (state)
      ST_IDLE:   in_stall  = 1'b0;
      ST_MUL_GO: mul_start = 1'b1;
      ST_DIV_GO: div_start = 1'b1;
      ST_OUT:    load_out  = !out_valid || !out_stall;
      default:   ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rounds <= '0;
      first  <= 1'b0;
    end else if (accept) begin
      rounds <= '0;
      first  <= 1'b1;
    end else begin
      if (mul_done) first <= 1'b0;
      if (state == ST_CHECK && !ok_now && !rounds_max) rounds <= rounds + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      lin_neg <= linear_vel[15];
      tan_neg <= angular_vel[15];
      lin_mag <= {16'b0, linear_vel[15] ? 16'(-linear_vel) : linear_vel};
      tan_mag <= {16'b0, angular_vel[15] ? 16'(-angular_vel) : angular_vel};
      scale   <= SCALE_ONE;
    end else begin
      if (mul_done) begin
        lin_mag <= first ? prod_l[MAG_W-1:0] : prod_l[MAG_W+15:16];
        tan_mag <= first ? prod_t[MAG_W-1:0] : prod_t[MAG_W+15:16];
      end
      if (state == ST_DIV_GO) begin
        left_neg  <= dl[SUM_W-1];
        right_neg <= dr[SUM_W-1];
      end
      if (state == ST_CHECK) begin
        ok_r <= ok_now;
        if (!ok_now) scale <= (scale >= SCALE_STEP) ? scale - SCALE_STEP : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (load_out) out_valid <= 1'b1;
    else if (out_valid && !out_stall) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      left_rpm     <= !ok_r ? '0 : left_neg ? RPM_W'(-quot_l[RPM_W-1:0]) : quot_l[RPM_W-1:0];
      right_rpm    <= !ok_r ? '0 : right_neg ? RPM_W'(-quot_r[RPM_W-1:0]) : quot_r[RPM_W-1:0];
      was_scaled   <= rounds != '0;
      scale_rounds <= (int'(rounds) > 31) ? 5'd31 : 5'(rounds);
    end
  end

  a_rounds_bound: assert property (@(posedge clk) disable iff (rst)
    int'(rounds) <= MAX_ROUNDS) else $error("round count past limit");

  a_scaled_flag: assert property (@(posedge clk) disable iff (rst)
    (out_valid && scale_rounds != 5'd0) |-> was_scaled) else $error("scaled flag mismatch");

  a_mul_done_wait: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> state == ST_MUL_WAIT) else $error("multiply finished outside wait");

  a_retry: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CHECK && !ok_now && !rounds_max) |=> state == ST_MUL_GO)
    else $error("failed check did not start a shrink round");

endmodule

// ===== dv/diff_drive_wheel_rpm_limiter_core_tb.sv =====
// Testbench for the differential-drive wheel rpm limiter core: directed and random commands and settings.
`timescale 1ns / 1ps

module diff_drive_wheel_rpm_limiter_core_tb;
  import ddwrl_pkg::*;

  localparam int ROUND_LIMIT = 30;
  localparam int WATCHDOG_CYCLES = 20000;
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    logic signed [16:0] left;
    logic signed [16:0] right;
    logic               scaled;
    logic [4:0]         rounds;
  } wheel_cmd_t;

  class wheel_speed_board;
    wheel_cmd_t pending[$];
    int unsigned errors;
    logic [20:0] circ_um;
    logic [11:0] track_mm;
    logic [11:0] rpm_max;

    function void set_reg(logic [1:0] idx, logic [20:0] val);
      case (idx)
        CFG_CIRC:   circ_um = val;
        CFG_TRACK:  track_mm = val[11:0];
        CFG_MAXRPM: rpm_max = val[11:0];
        default: ;
      endcase
    endfunction

    function void note_command(logic signed [15:0] lin_in, logic signed [15:0] ang_in);
      longint lin_um, tan_um, div, lim, l, r, s;
      int k;
      bit fits;
      wheel_cmd_t w;
      lin_um = longint'(lin_in) * 60000;
      tan_um = longint'(ang_in) * 30 * longint'(track_mm);
      div = (circ_um == 0) ? 1 : longint'(circ_um);
      lim = longint'(rpm_max) * 16;
      k = 0;
      fits = 0;
      forever begin
        l = ((lin_um - tan_um) * 16) / div;
        r = ((lin_um + tan_um) * 16) / div;
        if ((l < 0 ? -l : l) <= lim && (r < 0 ? -r : r) <= lim) begin
          fits = 1;
          break;
        end
        if (k >= ROUND_LIMIT) break;
        k++;
        s = 65536 - 2185 * k;
        if (s < 0) s = 0;
        lin_um = (lin_um * s) / 65536;
        tan_um = (tan_um * s) / 65536;
      end
      if (!fits) begin
        l = 0;
        r = 0;
      end
      w.left = l[16:0];
      w.right = r[16:0];
      w.scaled = (k > 0);
      w.rounds = (k > 31) ? 5'd31 : k[4:0];
      pending.push_back(w);
    endfunction

    function void check_result(wheel_cmd_t got);
      wheel_cmd_t exp_w;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        errors++;
        return;
      end
      exp_w = pending.pop_front();
      if (got.left !== exp_w.left)
        $display("%0t: left_rpm exp %0d got %0d", $time, exp_w.left, got.left);
      if (got.right !== exp_w.right)
        $display("%0t: right_rpm exp %0d got %0d", $time, exp_w.right, got.right);
      if (got.scaled !== exp_w.scaled)
        $display("%0t: was_scaled exp %0d got %0d", $time, exp_w.scaled, got.scaled);
      if (got.rounds !== exp_w.rounds)
        $display("%0t: scale_rounds exp %0d got %0d", $time, exp_w.rounds, got.rounds);
      if (got !== exp_w) errors++;
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  logic signed [15:0] linear_vel = 0;
  logic signed [15:0] angular_vel = 0;
  logic out_valid;
  logic out_stall = 0;
  logic signed [RPM_W-1:0] left_rpm;
  logic signed [RPM_W-1:0] right_rpm;
  logic was_scaled;
  logic [4:0] scale_rounds;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [1:0] cfg_index = 0;
  logic [CFG_W-1:0] cfg_data = 0;

  wheel_speed_board board;
  int unsigned idle_cycles;
  bit long_hold;

  always #1 clk = ~clk;

  diff_drive_wheel_rpm_limiter_core #(.MAX_ROUNDS(ROUND_LIMIT)) dut (.*);

  task automatic pause_cycles(int n);
    repeat (n) @(posedge clk);
  endtask

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 93) return $urandom_range(1, 4);
    return $urandom_range(20, 200);
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [20:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    board.set_reg(idx, val);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  task automatic send_command(logic signed [15:0] lin_in, logic signed [15:0] ang_in);
    in_valid <= 1;
    linear_vel <= lin_in;
    angular_vel <= ang_in;
    do @(posedge clk); while (in_stall);
    board.note_command(lin_in, ang_in);
    in_valid <= 0;
    pause_cycles(gap_len() + 1);
  endtask

  task automatic drain();
    while (board.pending.size() != 0) @(posedge clk);
    pause_cycles(50);
  endtask

  // mostly moderate speeds, the rest full 16-bit random values
  task automatic random_phase(int n);
    int p;
    logic signed [15:0] a, b;
    repeat (n) begin
      p = $urandom_range(0, 9);
      if (p < 6) begin
        a = 16'(int'($urandom_range(0, 4000)) - 2000);
        b = 16'(int'($urandom_range(0, 6000)) - 3000);
      end else begin
        a = 16'($urandom);
        b = 16'($urandom);
      end
      send_command(a, b);
    end
  endtask

  // receiver: random stalls plus one long hold-off
  always @(posedge clk) begin
    if (rst) out_stall <= 0;
    else if (long_hold) out_stall <= 1;
    else out_stall <= ($urandom_range(0, 99) < 30);
  end

  initial begin
    long_hold = 0;
    wait (!rst);
    pause_cycles(2000);
    long_hold = 1;
    pause_cycles(3000);
    long_hold = 0;
  end

  always @(posedge clk) begin
    if (out_valid && !out_stall)
      board.check_result('{left_rpm, right_rpm, was_scaled, scale_rounds});
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_valid)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("diff_drive_wheel_rpm_limiter_core_tb: FAIL");
      $finish;
    end
  end

  initial begin
    logic signed [15:0] ext[4];
    board = new();
    board.errors = 0;
    board.circ_um = CIRC_RST;
    board.track_mm = TRACK_RST;
    board.rpm_max = MAXRPM_RST;
    ext = '{16'sh8000, 16'sh7fff, 16'sh0000, -16'sd1};
    pause_cycles(4);
    rst <= 0;
    @(posedge clk);
    // directed: field extremes at reset settings
    foreach (ext[i]) foreach (ext[j]) send_command(ext[i], ext[j]);
    send_command(16'sd100, 16'sd50);
    send_command(16'sd1000, -16'sd800);
    drain();
    write_reg(CFG_UNUSED, 21'h1fffff);
    write_reg(CFG_CIRC, 21'd0);
    write_reg(CFG_MAXRPM, 21'd0);
    send_command(16'sd0, 16'sd0);
    send_command(16'sd1, 16'sd0);
    send_command(16'sh7fff, 16'sh8000);
    drain();
    write_reg(CFG_CIRC, 21'h1fffff);
    write_reg(CFG_TRACK, 21'hfff);
    write_reg(CFG_MAXRPM, 21'hfff);
    send_command(16'sh7fff, 16'sh7fff);
    send_command(16'sh8000, 16'sh7fff);
    drain();
    write_reg(CFG_CIRC, CIRC_RST);
    write_reg(CFG_TRACK, 21'(TRACK_RST));
    write_reg(CFG_MAXRPM, 21'(MAXRPM_RST));
    random_phase(600);
    drain();
    write_reg(CFG_CIRC, 21'd1000);
    write_reg(CFG_TRACK, 21'd1);
    write_reg(CFG_MAXRPM, 21'd1);
    random_phase(250);
    drain();
    repeat (4) begin
      write_reg(CFG_CIRC, 21'($urandom_range(1000, 2000000)));
      write_reg(CFG_TRACK, 21'($urandom_range(1, 4000)));
      write_reg(CFG_MAXRPM, 21'($urandom_range(1, 4095)));
      random_phase(210);
      drain();
    end
    if (board.errors == 0 && board.pending.size() == 0)
      $display("diff_drive_wheel_rpm_limiter_core_tb: PASS");
    else
      $display("diff_drive_wheel_rpm_limiter_core_tb: FAIL");
    $finish;
  end
endmodule
